>>> design/mgpa_pkg.sv
`default_nettype none
package mgpa_pkg;

  localparam int SLOT_W = 5;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_ADMIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_WB     = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

endpackage
`default_nettype wire

>>> design/mgpa_cell.sv
`default_nettype none
module mgpa_cell #(
  parameter int W = 10
) (
  input  wire logic         clk,
  input  wire logic         shift,
  input  wire logic [W-1:0] d_in,
  output logic      [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

>>> design/mixed_group_pair_admission_top.sv
// A slot out of range goes from CHECK straight to OUT; a slot that needs no search goes
// CHECK, DECIDE, OUT; a search goes CHECK, LOAD, DECIDE, OUT when no pair is found, and
// through WB before OUT when a pair is admitted and the queue is compacted (LOAD reads every
// queue entry into the cell row, WB writes the entries that stay back out of it).
// One item at a time: busy is high until the last result is shown; the
// receiver cannot stall. Reset (rst_n low, synchronous) clears occupancy and queue counts.
`default_nettype none
module mixed_group_pair_admission_top #(
  parameter int NUM_SLOTS   = 20,
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 6,
  parameter int GROUP_BITS  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_mode,
  input  wire logic [mgpa_pkg::SLOT_W-1:0] in_slot,
  input  wire logic [ID_BITS-1:0]          in_requester,
  input  wire logic [GROUP_BITS-1:0]       in_group_tag,
  output logic                             out_valid,
  output logic [mgpa_pkg::KIND_W-1:0]      out_kind,
  output logic [ID_BITS-1:0]               out_who,
  output logic [mgpa_pkg::SLOT_W-1:0]      out_slot_out,
  output logic                             out_last
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_SLOTS * QUEUE_DEPTH);
  localparam int EW = ID_BITS + GROUP_BITS;
  localparam int DEPTH_ALL = NUM_SLOTS * QUEUE_DEPTH;

  mgpa_pkg::state_t state_r, state_nxt;

  logic                        mode_r;
  logic [mgpa_pkg::SLOT_W-1:0] slot_r;
  logic [ID_BITS-1:0]          req_r;
  logic [GROUP_BITS-1:0]       grp_r;
  logic [1:0]                  occ_r [NUM_SLOTS];
  logic [CW-1:0]               cnt_r [NUM_SLOTS];
  logic [CW-1:0]               n_r;
  logic                        search_r;
  logic [CW-1:0]               rd_cnt_r;
  logic                        rv_r;
  logic [IW-1:0]               ridx_r;
  logic                        found_r;
  logic [IW-1:0]               k_r;
  logic [ID_BITS-1:0]          mate_r;
  logic [ID_BITS-1:0]          first_r;
  logic [GROUP_BITS-1:0]       g0_r;
  logic [IW-1:0]               wb_cnt_r;
  logic [IW-1:0]               w_r;
  logic                        two_r;
  logic                        pair_r;
  logic [mgpa_pkg::KIND_W-1:0] r1_kind_r, r2_kind_r;
  logic [ID_BITS-1:0]          r1_who_r, r2_who_r;
  logic [EW-1:0]               rdata_r;
  logic [EW-1:0]               mem [DEPTH_ALL];

  logic [EW-1:0]     cell_q [QUEUE_DEPTH];
  logic              shift;
  logic [SW-1:0]     sidx;
  logic              in_range;
  logic [AW-1:0]     base;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic              enqueue;
  logic              keep;
  logic [1:0]        occ_cur;
  logic [1:0]        occ_dec;
  logic [ID_BITS-1:0]    d_id;
  logic [GROUP_BITS-1:0] d_grp;
  logic              d_live;

  assign sidx     = SW'(slot_r);
  assign in_range = (9'(slot_r) < 9'(NUM_SLOTS));
  assign base     = AW'(AW'(sidx) * AW'(QUEUE_DEPTH));
  assign raddr    = AW'(base + AW'(rd_cnt_r[IW-1:0]));
  assign occ_cur  = occ_r[sidx];
  assign occ_dec  = (occ_cur != 2'd0) ? occ_cur - 2'd1 : occ_cur;
  assign d_id     = rdata_r[EW-1:GROUP_BITS];
  assign d_grp    = rdata_r[GROUP_BITS-1:0];
  assign d_live   = rv_r && (CW'(ridx_r) < n_r) && !found_r;
  assign shift    = (state_r == mgpa_pkg::ST_LOAD && rv_r) || (state_r == mgpa_pkg::ST_WB);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        mgpa_cell #(.W(EW)) u_cell (
          .clk(clk), .shift(shift), .d_in(rdata_r), .q(cell_q[gi])
        );
      end else begin : g_body
        mgpa_cell #(.W(EW)) u_cell (
          .clk(clk), .shift(shift), .d_in(cell_q[gi+1]), .q(cell_q[gi])
        );
      end
    end
  endgenerate

  assign enqueue = (state_r == mgpa_pkg::ST_DECIDE) && !mode_r && !(search_r && found_r)
                   && (n_r != CW'(QUEUE_DEPTH));
  assign keep    = (CW'(wb_cnt_r) < n_r) && (wb_cnt_r != k_r)
                   && !(mode_r && wb_cnt_r == '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(base + AW'(n_r[IW-1:0]));
    mem_wdata = {req_r, grp_r};
    if (enqueue) begin
      mem_we = 1'b1;
    end else if (state_r == mgpa_pkg::ST_WB && keep) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(base + AW'(w_r));
      mem_wdata = cell_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mgpa_pkg::ST_IDLE:   if (start) state_nxt = mgpa_pkg::ST_CHECK;
      mgpa_pkg::ST_CHECK: begin
        if (!in_range) begin
          state_nxt = mgpa_pkg::ST_OUT;
        end else if (mode_r ? (occ_dec == 2'd0 && cnt_r[sidx] >= CW'(2))
                            : (occ_cur == 2'd0)) begin
          state_nxt = mgpa_pkg::ST_LOAD;
        end else begin
          state_nxt = mgpa_pkg::ST_DECIDE;
        end
      end
      mgpa_pkg::ST_LOAD:   if (rd_cnt_r == CW'(QUEUE_DEPTH)) state_nxt = mgpa_pkg::ST_DECIDE;
      mgpa_pkg::ST_DECIDE: state_nxt = (search_r && found_r) ? mgpa_pkg::ST_WB
                                                              : mgpa_pkg::ST_OUT;
      mgpa_pkg::ST_WB:     if (wb_cnt_r == IW'(QUEUE_DEPTH - 1)) state_nxt = mgpa_pkg::ST_OUT;
      mgpa_pkg::ST_OUT:    if (!two_r) state_nxt = mgpa_pkg::ST_IDLE;
      default:             state_nxt = mgpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mgpa_pkg::ST_IDLE;
      two_r   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        occ_r[i] <= 2'd0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        mgpa_pkg::ST_IDLE: begin
          if (start) begin
            mode_r <= in_mode;
            slot_r <= in_slot;
            req_r  <= in_requester;
            grp_r  <= in_group_tag;
          end
        end
        mgpa_pkg::ST_CHECK: begin
          two_r    <= 1'b0;
          found_r  <= 1'b0;
          rd_cnt_r <= '0;
          rv_r     <= 1'b0;
          n_r      <= cnt_r[sidx];
          if (!in_range) begin
            r2_kind_r <= mode_r ? mgpa_pkg::KIND_LEFT : mgpa_pkg::KIND_DROP;
            r2_who_r  <= mode_r ? '0 : req_r;
          end else if (mode_r) begin
            occ_r[sidx] <= occ_dec;
            search_r    <= (occ_dec == 2'd0) && (cnt_r[sidx] >= CW'(2));
          end else begin
            search_r <= (occ_cur == 2'd0);
          end
        end
        mgpa_pkg::ST_LOAD: begin
          rv_r   <= (rd_cnt_r < CW'(QUEUE_DEPTH));
          ridx_r <= rd_cnt_r[IW-1:0];
          if (rd_cnt_r < CW'(QUEUE_DEPTH)) begin
            rd_cnt_r <= rd_cnt_r + CW'(1);
          end
          if (d_live) begin
            if (!mode_r) begin
              if (d_grp != grp_r) begin
                found_r <= 1'b1;
                k_r     <= ridx_r;
                mate_r  <= d_id;
              end
            end else if (ridx_r == '0) begin
              g0_r    <= d_grp;
              first_r <= d_id;
            end else if (d_grp != g0_r) begin
              found_r <= 1'b1;
              k_r     <= ridx_r;
              mate_r  <= d_id;
            end
          end
        end
        mgpa_pkg::ST_DECIDE: begin
          wb_cnt_r <= '0;
          w_r      <= '0;
          pair_r   <= search_r && found_r;
          if (search_r && found_r) begin
            occ_r[sidx] <= 2'd2;
            r1_kind_r   <= mgpa_pkg::KIND_ADMIT;
            r1_who_r    <= mode_r ? first_r : mate_r;
            r2_kind_r   <= mgpa_pkg::KIND_ADMIT;
            r2_who_r    <= mode_r ? mate_r : req_r;
          end else if (mode_r) begin
            r2_kind_r <= mgpa_pkg::KIND_LEFT;
            r2_who_r  <= '0;
          end else if (n_r == CW'(QUEUE_DEPTH)) begin
            r2_kind_r <= mgpa_pkg::KIND_DROP;
            r2_who_r  <= req_r;
          end else begin
            cnt_r[sidx] <= n_r + CW'(1);
            r2_kind_r   <= mgpa_pkg::KIND_QUEUED;
            r2_who_r    <= req_r;
          end
        end
        mgpa_pkg::ST_WB: begin
          wb_cnt_r <= wb_cnt_r + IW'(1);
          if (keep) begin
            w_r <= w_r + IW'(1);
          end
          if (wb_cnt_r == IW'(QUEUE_DEPTH - 1)) begin
            cnt_r[sidx] <= mode_r ? n_r - CW'(2) : n_r - CW'(1);
            two_r       <= pair_r;
          end
        end
        mgpa_pkg::ST_OUT: begin
          two_r <= 1'b0;
        end
        default: begin
          two_r <= 1'b0;
        end
      endcase
    end
  end

  assign busy         = (state_r != mgpa_pkg::ST_IDLE);
  assign out_valid    = (state_r == mgpa_pkg::ST_OUT);
  assign out_kind     = two_r ? r1_kind_r : r2_kind_r;
  assign out_who      = two_r ? r1_who_r : r2_who_r;
  assign out_slot_out = slot_r;
  assign out_last     = !two_r;

endmodule
`default_nettype wire

>>> tb/sv/mixed_group_pair_admission_checker.sv
`default_nettype none
module mixed_group_pair_admission_checker #(
  parameter int NUM_SLOTS   = 20,
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 6,
  parameter int GROUP_BITS  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic                        in_mode,
  input  wire logic [mgpa_pkg::SLOT_W-1:0] in_slot,
  input  wire logic [ID_BITS-1:0]          in_requester,
  input  wire logic [GROUP_BITS-1:0]       in_group_tag,
  input  wire logic                        out_valid,
  input  wire logic [mgpa_pkg::KIND_W-1:0] out_kind,
  input  wire logic [ID_BITS-1:0]          out_who,
  input  wire logic [mgpa_pkg::SLOT_W-1:0] out_slot_out,
  input  wire logic                        out_last,
  output int                               fail_count,
  output int                               pending,
  output int                               admit_count,
  output int                               drop_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mgpa_pkg::KIND_W-1:0] kind;
    logic [ID_BITS-1:0]          who;
    logic [mgpa_pkg::SLOT_W-1:0] slot;
    logic                        last;
  } verdict_t;

  logic [1:0]            occ [NUM_SLOTS];
  int                    qlen [NUM_SLOTS];
  logic [ID_BITS-1:0]    qid [NUM_SLOTS][QUEUE_DEPTH];
  logic [GROUP_BITS-1:0] qgrp [NUM_SLOTS][QUEUE_DEPTH];
  verdict_t              verdicts [$];

  function automatic verdict_t mk(logic [mgpa_pkg::KIND_W-1:0] k, logic [ID_BITS-1:0] w,
                                  logic [mgpa_pkg::SLOT_W-1:0] s, logic l);
    verdict_t v;
    v.kind = k; v.who = w; v.slot = s; v.last = l;
    return v;
  endfunction

  task automatic pull_waiter(int s, int k);
    for (int j = k; j + 1 < qlen[s]; j++) begin
      qid[s][j] = qid[s][j+1];
      qgrp[s][j] = qgrp[s][j+1];
    end
    qlen[s]--;
  endtask

  task automatic admit_step(logic m, logic [mgpa_pkg::SLOT_W-1:0] s,
                            logic [ID_BITS-1:0] r, logic [GROUP_BITS-1:0] g);
    int k;
    int n;
    if (s >= NUM_SLOTS) begin
      if (!m) verdicts.push_back(mk(mgpa_pkg::KIND_DROP, r, s, 1'b1));
      else verdicts.push_back(mk(mgpa_pkg::KIND_LEFT, '0, s, 1'b1));
      return;
    end
    n = qlen[s];
    if (!m) begin
      if (occ[s] == 0) begin
        for (k = 0; k < n; k++) if (qgrp[s][k] != g) break;
        if (k < n) begin
          verdicts.push_back(mk(mgpa_pkg::KIND_ADMIT, qid[s][k], s, 1'b0));
          verdicts.push_back(mk(mgpa_pkg::KIND_ADMIT, r, s, 1'b1));
          pull_waiter(s, k);
          occ[s] = 2'd2;
          return;
        end
      end
      if (n >= QUEUE_DEPTH) begin
        verdicts.push_back(mk(mgpa_pkg::KIND_DROP, r, s, 1'b1));
        return;
      end
      qid[s][n] = r;
      qgrp[s][n] = g;
      qlen[s]++;
      verdicts.push_back(mk(mgpa_pkg::KIND_QUEUED, r, s, 1'b1));
      return;
    end
    if (occ[s] > 0) occ[s]--;
    if (occ[s] == 0 && n >= 2) begin
      for (k = 1; k < n; k++) if (qgrp[s][k] != qgrp[s][0]) break;
      if (k < n) begin
        verdicts.push_back(mk(mgpa_pkg::KIND_ADMIT, qid[s][0], s, 1'b0));
        verdicts.push_back(mk(mgpa_pkg::KIND_ADMIT, qid[s][k], s, 1'b1));
        pull_waiter(s, k);
        pull_waiter(s, 0);
        occ[s] = 2'd2;
        return;
      end
    end
    verdicts.push_back(mk(mgpa_pkg::KIND_LEFT, '0, s, 1'b1));
  endtask

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        occ[i] = '0;
        qlen[i] = 0;
      end
      verdicts.delete();
      fail_count = 0;
      admit_count = 0;
      drop_count = 0;
    end else begin
      if (out_valid) begin
        got = mk(out_kind, out_who, out_slot_out, out_last);
        if (got.kind == mgpa_pkg::KIND_ADMIT) admit_count++;
        if (got.kind == mgpa_pkg::KIND_DROP) drop_count++;
        if (verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = verdicts.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (start && !busy) admit_step(in_mode, in_slot, in_requester, in_group_tag);
    end
    pending = verdicts.size();
  end
endmodule
`default_nettype wire

>>> tb/sv/mixed_group_pair_admission_top_tb.sv
`default_nettype none
module mixed_group_pair_admission_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_mode = 1'b0;
  logic [4:0] in_slot = '0;
  logic [5:0] in_requester = '0;
  logic [3:0] in_group_tag = '0;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [5:0] out_who;
  logic [4:0] out_slot_out;
  logic       out_last;
  int         fail_count;
  int         pending;
  int         admit_count;
  int         drop_count;
  int         sent = 0;

  always #4 clk = ~clk;

  mixed_group_pair_admission_top dut (.*);

  mixed_group_pair_admission_checker checker_i (.*);

  task automatic send(logic m, logic [4:0] s, logic [5:0] r, logic [3:0] g);
    @(negedge clk);
    in_mode = m; in_slot = s; in_requester = r; in_group_tag = g;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) @(negedge clk);
  endtask

  task automatic random_item(int pct);
    int sel;
    logic [4:0] s;
    idle_gap(pct);
    sel = $urandom_range(99);
    s = (sel < 85) ? 5'($urandom_range(3)) :
        (sel < 95) ? 5'($urandom_range(19)) : 5'($urandom_range(31));
    if ($urandom_range(99) < 55)
      send(1'b0, s, 6'($urandom), 4'($urandom_range(99) < 70 ? $urandom_range(1) : $urandom));
    else
      send(1'b1, s, 6'($urandom), 4'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send(1'b1, 5'd0, 6'd0, 4'd0);
    send(1'b0, 5'd0, 6'd63, 4'd15);
    send(1'b0, 5'd0, 6'd0, 4'd0);
    send(1'b0, 5'd0, 6'd5, 4'd15);
    send(1'b1, 5'd0, 6'd63, 4'd15);
    send(1'b1, 5'd0, 6'd0, 4'd0);
    send(1'b0, 5'd0, 6'd7, 4'd3);
    send(1'b0, 5'd20, 6'd42, 4'd1);
    send(1'b1, 5'd31, 6'd21, 4'd9);
    send(1'b0, 5'd19, 6'd1, 4'd1);
    send(1'b0, 5'd19, 6'd2, 4'd1);
    send(1'b0, 5'd19, 6'd3, 4'd2);
    send(1'b1, 5'd19, 6'd0, 4'd0);
    send(1'b1, 5'd19, 6'd0, 4'd0);
    for (int i = 0; i < 65; i++) send(1'b0, 5'd5, 6'(i), 4'd6);
    send(1'b1, 5'd5, 6'd0, 4'd0);
    send(1'b0, 5'd5, 6'd9, 4'd7);
    for (int i = 0; i < 450; i++) random_item(29);
    for (int i = 0; i < 450; i++) random_item(72);
    for (int i = 0; i < 450; i++) random_item(0);
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    $display("sent %0d items across 20 slots and out-of-range indexes", sent);
    $display("saw %0d admissions and %0d drops", admit_count, drop_count);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
